>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the convolution unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/brc_pkg.sv
// Package with types, constants and helpers of the convolution unit.
`timescale 1ns / 1ps

package brc_pkg;

  localparam int PIX_W     = 16;
  localparam int COEF_W    = 17;
  localparam int PROD_W    = PIX_W + COEF_W;
  localparam int POS_W     = 12;
  localparam int ROWCOL_W  = 7;
  localparam int CIDX_W    = 6;
  localparam int RADCFG_W  = 2;
  localparam int DIMCFG_W  = 8;
  localparam int OPC_W     = 2;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int QUO_STEPS = PIX_W;

  localparam int DEF_MAX_ROWS   = 128;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_MAX_RADIUS = 3;

  localparam logic [1:0] REG_RADIUS_ROWS = 2'd0;
  localparam logic [1:0] REG_RADIUS_COLS = 2'd1;
  localparam logic [1:0] REG_IMAGE_ROWS  = 2'd2;
  localparam logic [1:0] REG_IMAGE_COLS  = 2'd3;

  localparam logic [RADCFG_W-1:0] RST_RADIUS = 2'd1;
  localparam logic [DIMCFG_W-1:0] RST_DIM    = 8'd128;

  typedef enum logic [1:0] {
    OP_WR_COEF = 2'd0,
    OP_WR_PIX  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_FIN
  } seq_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_LOOP,
    D_DONE
  } div_state_t;

  typedef struct packed {
    logic [RADCFG_W-1:0] radius_rows;
    logic [RADCFG_W-1:0] radius_cols;
    logic [DIMCFG_W-1:0] image_rows;
    logic [DIMCFG_W-1:0] image_cols;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic tap;
    logic wr_coef;
    logic wr_pix;
    logic div_start;
    logic fin;
    op_t  op;
  } ctl_t;

  function automatic int clog2_min1(input int v);
    return (v <= 2) ? 1 : $clog2(v);
  endfunction

endpackage

>>> rtl/brc_apb.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module brc_apb (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brc_pkg::APB_AW-1:0]  paddr,
  input  logic [brc_pkg::APB_DW-1:0]  pwdata,
  output logic [brc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output brc_pkg::cfg_t               cfg
);
  import brc_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius_rows <= RST_RADIUS;
      cfg.radius_cols <= RST_RADIUS;
      cfg.image_rows  <= RST_DIM;
      cfg.image_cols  <= RST_DIM;
    end else if (wr) begin
      case (paddr[3:2])
        REG_RADIUS_ROWS: cfg.radius_rows <= pwdata[RADCFG_W-1:0];
        REG_RADIUS_COLS: cfg.radius_cols <= pwdata[RADCFG_W-1:0];
        REG_IMAGE_ROWS:  cfg.image_rows  <= pwdata[DIMCFG_W-1:0];
        REG_IMAGE_COLS:  cfg.image_cols  <= pwdata[DIMCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS_ROWS: prdata = APB_DW'(cfg.radius_rows);
      REG_RADIUS_COLS: prdata = APB_DW'(cfg.radius_cols);
      REG_IMAGE_ROWS:  prdata = APB_DW'(cfg.image_rows);
      REG_IMAGE_COLS:  prdata = APB_DW'(cfg.image_cols);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/brc_seq.sv
// Sequencer: item handshake, kernel tap walk and window clipping.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brc_seq #(
  parameter int  MAX_ROWS   = brc_pkg::DEF_MAX_ROWS,
  parameter int  MAX_COLS   = brc_pkg::DEF_MAX_COLS,
  parameter int  MAX_RADIUS = brc_pkg::DEF_MAX_RADIUS,
  localparam int KSIDE      = 2 * MAX_RADIUS + 1,
  localparam int KDEPTH     = KSIDE * KSIDE,
  localparam int KAW        = brc_pkg::clog2_min1(KDEPTH),
  localparam int TW         = brc_pkg::clog2_min1(KSIDE),
  localparam int AW         = brc_pkg::clog2_min1(MAX_ROWS * MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  brc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [brc_pkg::OPC_W-1:0]     opcode,
  input  logic [brc_pkg::ROWCOL_W-1:0]  row,
  input  logic [brc_pkg::ROWCOL_W-1:0]  col,
  input  logic                          mac_busy,
  input  logic                          div_done,
  input  logic                          out_free,
  output brc_pkg::ctl_t                 ctl,
  output logic [KAW-1:0]                kaddr,
  output logic [AW-1:0]                 iaddr,
  output logic                          cut
);
  import brc_pkg::*;

  seq_state_t            state, state_next;
  op_t                   op;
  logic [ROWCOL_W-1:0]   row_q, col_q;
  logic [TW-1:0]         ti, tj, rr, rc, i_last, j_last;
  logic [DIMCFG_W-1:0]   nrows, ncols;
  logic [POS_W-1:0]      pr, pc;
  logic                  in_window, accept, last_col, last_tap;

  assign rr = (int'(cfg.radius_rows) > MAX_RADIUS) ? TW'(MAX_RADIUS) : TW'(cfg.radius_rows);
  assign rc = (int'(cfg.radius_cols) > MAX_RADIUS) ? TW'(MAX_RADIUS) : TW'(cfg.radius_cols);
  assign nrows = (int'(cfg.image_rows) > MAX_ROWS) ? DIMCFG_W'(MAX_ROWS) : cfg.image_rows;
  assign ncols = (int'(cfg.image_cols) > MAX_COLS) ? DIMCFG_W'(MAX_COLS) : cfg.image_cols;
  assign i_last = rr + rr;
  assign j_last = rc + rc;

  assign pr = POS_W'(row_q) + POS_W'(ti) - POS_W'(rr);
  assign pc = POS_W'(col_q) + POS_W'(tj) - POS_W'(rc);
  assign in_window = !pr[POS_W-1] && !pc[POS_W-1] &&
                     (pr < POS_W'(nrows)) && (pc < POS_W'(ncols));
  assign iaddr = AW'(AW'(pr[DIMCFG_W-1:0]) * AW'(MAX_COLS)) + AW'(pc[DIMCFG_W-1:0]);

  assign last_col = (tj == j_last);
  assign last_tap = last_col && (ti == i_last);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == OP_COMPUTE) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    ctl.start     = in_valid && (state == S_IDLE) && (opcode == OP_COMPUTE);
    ctl.wr_coef   = in_valid && (state == S_IDLE) && (opcode == OP_WR_COEF);
    ctl.wr_pix    = in_valid && (state == S_IDLE) && (opcode == OP_WR_PIX);
    ctl.tap       = (state == S_SCAN) && in_window;
    ctl.div_start = (state == S_DRAIN) && !mac_busy;
    ctl.fin       = (state == S_FIN) && out_free;
    ctl.op        = op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= op_t'(opcode);
      row_q <= row;
      col_q <= col;
      ti    <= '0;
      tj    <= '0;
      kaddr <= '0;
      cut   <= 1'b0;
    end else if (state == S_SCAN) begin
      cut   <= cut | !in_window;
      kaddr <= kaddr + 1'b1;
      if (last_col) begin
        tj <= '0;
        ti <= ti + 1'b1;
      end else begin
        tj <= tj + 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_kaddr_in_range, clk, rst, state == S_SCAN, int'(kaddr) < KDEPTH)

endmodule

>>> rtl/brc_mac.sv
// Kernel and image memories with the shared multiply-accumulate unit.
`timescale 1ns / 1ps

module brc_mac #(
  parameter int  MAX_ROWS   = brc_pkg::DEF_MAX_ROWS,
  parameter int  MAX_COLS   = brc_pkg::DEF_MAX_COLS,
  parameter int  MAX_RADIUS = brc_pkg::DEF_MAX_RADIUS,
  localparam int KSIDE      = 2 * MAX_RADIUS + 1,
  localparam int KDEPTH     = KSIDE * KSIDE,
  localparam int KAW        = brc_pkg::clog2_min1(KDEPTH),
  localparam int AW         = brc_pkg::clog2_min1(MAX_ROWS * MAX_COLS),
  localparam int ACC_W      = brc_pkg::PROD_W + brc_pkg::clog2_min1(KDEPTH),
  localparam int WS_W       = brc_pkg::COEF_W + brc_pkg::clog2_min1(KDEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  brc_pkg::ctl_t                 ctl,
  input  logic [brc_pkg::ROWCOL_W-1:0]  row,
  input  logic [brc_pkg::ROWCOL_W-1:0]  col,
  input  logic [brc_pkg::PIX_W-1:0]     pixel_value,
  input  logic [brc_pkg::CIDX_W-1:0]    coef_index,
  input  logic [brc_pkg::COEF_W-1:0]    coef_value,
  input  logic [KAW-1:0]                kaddr,
  input  logic [AW-1:0]                 iaddr,
  output logic                          busy,
  output logic [ACC_W-1:0]              acc,
  output logic [WS_W-1:0]               wsum
);
  import brc_pkg::*;

  logic [COEF_W-1:0] kmem [KDEPTH];
  logic [PIX_W-1:0]  imem [MAX_ROWS * MAX_COLS];
  logic [COEF_W-1:0] kdata, kd2;
  logic [PIX_W-1:0]  idata;
  logic [PROD_W-1:0] prod;
  logic [AW-1:0]     waddr;
  logic              v1, v2, coef_ok, pix_ok;

  assign coef_ok = int'(coef_index) < KDEPTH;
  assign pix_ok  = (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
  assign waddr   = AW'(AW'(row) * AW'(MAX_COLS)) + AW'(col);
  assign busy    = v1 || v2;

  always_ff @(posedge clk) begin
    if (ctl.wr_coef && coef_ok) begin
      kmem[KAW'(coef_index)] <= coef_value;
    end
    kdata <= kmem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_pix && pix_ok) begin
      imem[waddr] <= pixel_value;
    end
    idata <= imem[iaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.tap;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(kdata) * PROD_W'(idata);
    kd2  <= kdata;
    if (ctl.start) begin
      acc  <= '0;
      wsum <= '0;
    end else if (v2) begin
      acc  <= acc + ACC_W'(prod);
      wsum <= wsum + WS_W'(kd2);
    end
  end

endmodule

>>> rtl/brc_div.sv
// Normalisation unit: shift for full windows, restoring division for clipped ones.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brc_div #(
  parameter int ACC_W = brc_pkg::PROD_W + 6,
  parameter int WS_W  = brc_pkg::COEF_W + 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       cut,
  input  logic [ACC_W-1:0]           acc,
  input  logic [WS_W-1:0]            wsum,
  output logic                       done,
  output logic [brc_pkg::PIX_W-1:0]  quo
);
  import brc_pkg::*;

  localparam int CNT_W = clog2_min1(QUO_STEPS);

  div_state_t         state, state_next;
  logic [ACC_W-1:0]   rem, dsh, thr;
  logic [CNT_W-1:0]   cnt;
  logic               ge, early, sat;

  assign thr   = ACC_W'({wsum, {PIX_W{1'b0}}});
  assign ge    = (rem >= dsh);
  assign sat   = |rem[ACC_W-1:2*PIX_W];
  assign early = !cut || (wsum == '0) || (rem >= thr);

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE: begin
        if (start) begin
          state_next = D_CHECK;
        end
      end
      D_CHECK: state_next = early ? D_DONE : D_LOOP;
      D_LOOP: begin
        if (cnt == CNT_W'(QUO_STEPS - 1)) begin
          state_next = D_DONE;
        end
      end
      D_DONE: state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_comb begin
    done = (state == D_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        if (start) begin
          rem <= acc;
          dsh <= thr >> 1;
          cnt <= '0;
          quo <= '0;
        end
      end
      D_CHECK: begin
        if (!cut) begin
          quo <= sat ? '1 : rem[2*PIX_W-1:PIX_W];
        end else if (wsum == '0) begin
          quo <= '0;
        end else if (rem >= thr) begin
          quo <= '1;
        end
      end
      D_LOOP: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quo <= {quo[PIX_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  `ASSERT_IMPLIES(a_rem_bound, clk, rst, state == D_LOOP, {1'b0, rem} < {dsh, 1'b0})

endmodule

>>> rtl/border_renormalized_convolution_unit.sv
// Top level of the border-renormalised convolution unit.
//
// One transaction is taken at a time. Coefficient writes, pixel writes and
// maximum clears load their result from the S_FIN state once the output is
// free. A compute walks the (2*radius_rows+1) x (2*radius_cols+1) kernel at
// one tap per cycle through the single 17x16 multiplier, drains the product
// pipeline and loads its result once the output is free; a full window is
// normalised by a shift, and for a clipped window with a non-zero coefficient
// sum the quotient comes from a restoring divider at one bit per cycle. The
// next transaction can be accepted in the cycle after the result is loaded.
// The next transaction is accepted while a finished result still waits on the
// output. Neither memory is cleared by reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module border_renormalized_convolution_unit #(
  parameter int MAX_ROWS   = brc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = brc_pkg::DEF_MAX_COLS,
  parameter int MAX_RADIUS = brc_pkg::DEF_MAX_RADIUS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brc_pkg::APB_AW-1:0]    paddr,
  input  logic [brc_pkg::APB_DW-1:0]    pwdata,
  output logic [brc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [brc_pkg::OPC_W-1:0]     opcode,
  input  logic [brc_pkg::ROWCOL_W-1:0]  row,
  input  logic [brc_pkg::ROWCOL_W-1:0]  col,
  input  logic [brc_pkg::PIX_W-1:0]     pixel_value,
  input  logic [brc_pkg::CIDX_W-1:0]    coef_index,
  input  logic [brc_pkg::COEF_W-1:0]    coef_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [brc_pkg::PIX_W-1:0]     result_pixel,
  output logic [brc_pkg::PIX_W-1:0]     peak_pixel,
  output logic                          window_clipped
);
  import brc_pkg::*;

  localparam int KSIDE  = 2 * MAX_RADIUS + 1;
  localparam int KDEPTH = KSIDE * KSIDE;
  localparam int KAW    = clog2_min1(KDEPTH);
  localparam int AW     = clog2_min1(MAX_ROWS * MAX_COLS);
  localparam int ACC_W  = PROD_W + clog2_min1(KDEPTH);
  localparam int WS_W   = COEF_W + clog2_min1(KDEPTH);

  cfg_t              cfg;
  ctl_t              ctl;
  logic [KAW-1:0]    kaddr;
  logic [AW-1:0]     iaddr;
  logic [ACC_W-1:0]  acc;
  logic [WS_W-1:0]   wsum;
  logic [PIX_W-1:0]  quo, res_next, max_next;
  logic              cut, mac_busy, div_done, out_free, clip_next;

  brc_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brc_seq #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .row      (row),
    .col      (col),
    .mac_busy (mac_busy),
    .div_done (div_done),
    .out_free (out_free),
    .ctl      (ctl),
    .kaddr    (kaddr),
    .iaddr    (iaddr),
    .cut      (cut)
  );

  brc_mac #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_mac (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .row         (row),
    .col         (col),
    .pixel_value (pixel_value),
    .coef_index  (coef_index),
    .coef_value  (coef_value),
    .kaddr       (kaddr),
    .iaddr       (iaddr),
    .busy        (mac_busy),
    .acc         (acc),
    .wsum        (wsum)
  );

  brc_div #(
    .ACC_W (ACC_W),
    .WS_W  (WS_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .cut   (cut),
    .acc   (acc),
    .wsum  (wsum),
    .done  (div_done),
    .quo   (quo)
  );

  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (ctl.op)
      OP_COMPUTE: begin
        res_next  = quo;
        clip_next = cut;
        max_next  = (quo > peak_pixel) ? quo : peak_pixel;
      end
      OP_CLEAR: begin
        res_next  = '0;
        clip_next = 1'b0;
        max_next  = '0;
      end
      default: begin
        res_next  = '0;
        clip_next = 1'b0;
        max_next  = peak_pixel;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      peak_pixel <= '0;
    end else begin
      if (ctl.fin) begin
        out_valid  <= 1'b1;
        peak_pixel <= max_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      result_pixel   <= res_next;
      window_clipped <= clip_next;
    end
  end

  `ASSERT_IMPLIES(a_result_le_max, clk, rst, out_valid, result_pixel <= peak_pixel)

endmodule

>>> tb/sv/border_renormalized_convolution_unit_tb.sv
// Self-checking testbench for the border-renormalised convolution unit.
`timescale 1ns / 1ps

module border_renormalized_convolution_unit_tb;
  import brc_pkg::*;

  localparam int KERNEL_DEPTH = (2 * DEF_MAX_RADIUS + 1) * (2 * DEF_MAX_RADIUS + 1);
  localparam int IMAGE_DEPTH  = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int IMG_AW       = $clog2(IMAGE_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] peak;
    logic             clipped;
  } conv_result_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [OPC_W-1:0]    opcode;
  logic [ROWCOL_W-1:0] row;
  logic [ROWCOL_W-1:0] col;
  logic [PIX_W-1:0]    pixel_value;
  logic [CIDX_W-1:0]   coef_index;
  logic [COEF_W-1:0]   coef_value;
  logic                out_valid;
  logic                out_ready;
  logic [PIX_W-1:0]    result_pixel;
  logic [PIX_W-1:0]    peak_pixel;
  logic                window_clipped;

  cfg_t             cfg_mirror;
  logic [PIX_W-1:0]  img_mirror [IMAGE_DEPTH];
  bit                pix_written [IMAGE_DEPTH];
  logic [COEF_W-1:0] kern_mirror [KERNEL_DEPTH];
  logic [PIX_W-1:0]  peak_mirror;
  conv_result_t      pending_results [$];

  int error_count;
  int items_sent;
  int hold_cycles;
  bit src_idle_on;
  bit sink_idle_on;
  bit tail_quiet;

  border_renormalized_convolution_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .row            (row),
    .col            (col),
    .pixel_value    (pixel_value),
    .coef_index     (coef_index),
    .coef_value     (coef_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_pixel   (result_pixel),
    .peak_pixel     (peak_pixel),
    .window_clipped (window_clipped)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  function automatic int eff_dim(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic conv_result_t filter_pixel(input int r, input int c);
    int rr, rc, nr, nc, kw, i, j, pr, pc, k;
    longint unsigned acc, wsum, q;
    conv_result_t res;
    rr = int'(cfg_mirror.radius_rows);
    rc = int'(cfg_mirror.radius_cols);
    nr = eff_dim(int'(cfg_mirror.image_rows), DEF_MAX_ROWS);
    nc = eff_dim(int'(cfg_mirror.image_cols), DEF_MAX_COLS);
    kw = 2 * rc + 1;
    acc = 0;
    wsum = 0;
    res = '0;
    for (i = -rr; i <= rr; i++) begin
      for (j = -rc; j <= rc; j++) begin
        pr = r + i;
        pc = c + j;
        k = (i + rr) * kw + (j + rc);
        if (pr < 0 || pc < 0 || pr >= nr || pc >= nc) begin
          res.clipped = 1'b1;
        end else begin
          acc += 64'(kern_mirror[CIDX_W'(k)]) *
                 64'(img_mirror[IMG_AW'(pr * DEF_MAX_COLS + pc)]);
          wsum += 64'(kern_mirror[CIDX_W'(k)]);
        end
      end
    end
    if (res.clipped) begin
      q = (wsum == 0) ? 0 : acc / wsum;
    end else begin
      q = acc >> 16;
    end
    res.pixel = (q > 64'd65535) ? 16'hFFFF : q[PIX_W-1:0];
    return res;
  endfunction

  function automatic conv_result_t predict_item(input op_t op, input logic [ROWCOL_W-1:0] r,
                                                input logic [ROWCOL_W-1:0] c,
                                                input logic [PIX_W-1:0] pv,
                                                input logic [CIDX_W-1:0] ci,
                                                input logic [COEF_W-1:0] cv);
    conv_result_t res;
    res = '0;
    case (op)
      OP_WR_COEF: begin
        if (ci < KERNEL_DEPTH) kern_mirror[ci] = cv;
      end
      OP_WR_PIX: begin
        img_mirror[{r, c}] = pv;
        pix_written[{r, c}] = 1'b1;
      end
      OP_COMPUTE: begin
        res = filter_pixel(int'(r), int'(c));
        if (res.pixel > peak_mirror) peak_mirror = res.pixel;
      end
      OP_CLEAR: begin
        peak_mirror = '0;
      end
      default: begin
      end
    endcase
    res.peak = peak_mirror;
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hFFFF;
      default: return PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(input bit sparse);
    if (sparse && $urandom_range(0, 1) == 0) return '0;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'h10000;
      2: return 17'h1FFFF;
      default: return COEF_W'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic int pick_coord(input int n);
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 127);
      1, 2: return $urandom_range(0, 3);
      3, 4: return (n > 4) ? $urandom_range(n - 4, n - 1) : $urandom_range(0, 3);
      default: return (n == 0) ? 0 : $urandom_range(0, ((n > 16) ? 16 : n) - 1);
    endcase
  endfunction

  task automatic send_item(input op_t op, input logic [ROWCOL_W-1:0] r,
                           input logic [ROWCOL_W-1:0] c, input logic [PIX_W-1:0] pv,
                           input logic [CIDX_W-1:0] ci, input logic [COEF_W-1:0] cv);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    opcode = op;
    row = r;
    col = c;
    pixel_value = pv;
    coef_index = ci;
    coef_value = cv;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_item(op, r, c, pv, ci, cv));
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_coef(input int idx, input logic [COEF_W-1:0] val);
    send_item(OP_WR_COEF, ROWCOL_W'($urandom_range(0, 127)), ROWCOL_W'($urandom_range(0, 127)),
              PIX_W'($urandom_range(0, 65535)), CIDX_W'(idx), val);
  endtask

  task automatic send_pixel(input int r, input int c, input logic [PIX_W-1:0] val);
    send_item(OP_WR_PIX, ROWCOL_W'(r), ROWCOL_W'(c), val, CIDX_W'($urandom_range(0, 63)),
              COEF_W'($urandom_range(0, 131071)));
  endtask

  task automatic send_compute(input int r, input int c);
    send_item(OP_COMPUTE, ROWCOL_W'(r), ROWCOL_W'(c), PIX_W'($urandom_range(0, 65535)),
              CIDX_W'($urandom_range(0, 63)), COEF_W'($urandom_range(0, 131071)));
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, ROWCOL_W'($urandom_range(0, 127)), ROWCOL_W'($urandom_range(0, 127)),
              PIX_W'($urandom_range(0, 65535)), CIDX_W'($urandom_range(0, 63)),
              COEF_W'($urandom_range(0, 131071)));
  endtask

  // Pixels under the window that were never written are filled first.
  task automatic compute_at(input int r, input int c);
    int rr, rc, nr, nc, i, j, pr, pc;
    rr = int'(cfg_mirror.radius_rows);
    rc = int'(cfg_mirror.radius_cols);
    nr = eff_dim(int'(cfg_mirror.image_rows), DEF_MAX_ROWS);
    nc = eff_dim(int'(cfg_mirror.image_cols), DEF_MAX_COLS);
    for (i = -rr; i <= rr; i++) begin
      for (j = -rc; j <= rc; j++) begin
        pr = r + i;
        pc = c + j;
        if (pr >= 0 && pc >= 0 && pr < nr && pc < nc) begin
          if (!pix_written[IMG_AW'(pr * DEF_MAX_COLS + pc)]) send_pixel(pr, pc, rand_pixel());
        end
      end
    end
    send_compute(r, c);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    logic [APB_DW-1:0] mask, wd, rd;
    mask = (idx == REG_RADIUS_ROWS || idx == REG_RADIUS_COLS) ? 32'h3 : 32'hFF;
    wd = ($urandom() & ~mask) | (value & mask);
    apb_access(1'b1, {idx, 2'b00}, wd, rd);
    case (idx)
      REG_RADIUS_ROWS: cfg_mirror.radius_rows = wd[RADCFG_W-1:0];
      REG_RADIUS_COLS: cfg_mirror.radius_cols = wd[RADCFG_W-1:0];
      REG_IMAGE_ROWS:  cfg_mirror.image_rows = wd[DIMCFG_W-1:0];
      REG_IMAGE_COLS:  cfg_mirror.image_cols = wd[DIMCFG_W-1:0];
      default: begin
      end
    endcase
    apb_access(1'b0, {idx, 2'b00}, $urandom(), rd);
    if (rd !== (wd & mask)) begin
      flag_error($sformatf("register %0d read back: expected %0h, got %0h", idx, wd & mask, rd));
    end
  endtask

  task automatic set_geometry(input int rr, input int rc, input int nr, input int nc);
    wait_results_drained();
    write_reg(REG_RADIUS_ROWS, rr);
    write_reg(REG_RADIUS_COLS, rc);
    write_reg(REG_IMAGE_ROWS, nr);
    write_reg(REG_IMAGE_COLS, nc);
  endtask

  task automatic load_kernel(input bit sparse);
    int k, taps;
    taps = (2 * int'(cfg_mirror.radius_rows) + 1) * (2 * int'(cfg_mirror.radius_cols) + 1);
    for (k = 0; k < taps; k++) send_coef(k, rand_coef(sparse));
  endtask

  task automatic run_mixed_traffic(input int count, input bit sparse);
    int start, loops, nr, nc, pick;
    start = items_sent;
    loops = 0;
    nr = eff_dim(int'(cfg_mirror.image_rows), DEF_MAX_ROWS);
    nc = eff_dim(int'(cfg_mirror.image_cols), DEF_MAX_COLS);
    while (items_sent - start < count) begin
      if (loops % 32 == 0 && !tail_quiet) begin
        src_idle_on = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      loops++;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        compute_at(pick_coord(nr), pick_coord(nc));
      end else if (pick < 75) begin
        if (nr > 0 && nc > 0 && $urandom_range(0, 9) < 7) begin
          send_pixel($urandom_range(0, nr - 1), $urandom_range(0, nc - 1), rand_pixel());
        end else begin
          send_pixel($urandom_range(0, 127), $urandom_range(0, 127), rand_pixel());
        end
      end else if (pick < 90) begin
        send_coef(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 48),
                  rand_coef(sparse));
      end else if (pick < 97) begin
        send_clear();
      end else begin
        wait_results_drained();
      end
    end
  endtask

  task automatic test_directed_cases();
    int i;
    set_geometry(1, 1, 3, 3);
    for (i = 0; i < 9; i++) send_pixel(i / 3, i % 3, (i == 8) ? 16'h0000 : 16'hFFFF);
    for (i = 0; i < 9; i++) send_coef(i, '0);
    send_coef(49, 17'h1FFFF);
    send_coef(63, 17'h00001);
    send_compute(0, 0);
    send_compute(1, 1);
    send_coef(4, 17'h1FFFF);
    send_compute(1, 1);
    send_compute(0, 0);
    send_compute(2, 2);
    send_coef(0, 17'h10000);
    send_compute(127, 127);
    send_compute(3, 3);
    send_compute(1, 1);
    send_clear();
    send_compute(0, 0);
    set_geometry(1, 1, 0, 3);
    send_compute(0, 0);
    send_compute(2, 1);
  endtask

  task automatic test_flow_control();
    int i;
    set_geometry(3, 3, 7, 7);
    load_kernel(1'b0);
    wait_results_drained();
    hold_cycles = 400;
    for (i = 0; i < 16; i++) compute_at($urandom_range(0, 6), $urandom_range(0, 6));
    wait_results_drained();
    for (i = 0; i < 8; i++) compute_at($urandom_range(0, 6), $urandom_range(0, 6));
  endtask

  task automatic test_random_phases();
    int p, rr, rc, nr, nc;
    for (p = 0; p < 10; p++) begin
      case (p)
        0: begin rr = 1; rc = 1; nr = 8; nc = 8; end
        1: begin rr = 3; rc = 3; nr = 7; nc = 7; end
        2: begin rr = 0; rc = 0; nr = 1; nc = 1; end
        3: begin rr = 2; rc = 1; nr = 128; nc = 5; end
        4: begin rr = 3; rc = 3; nr = 255; nc = 200; end
        5: begin rr = 0; rc = 3; nr = 0; nc = 16; end
        6: begin rr = 3; rc = 0; nr = 12; nc = 1; end
        7: begin rr = 1; rc = 2; nr = 5; nc = 40; end
        default: begin
          rr = $urandom_range(0, 3);
          rc = $urandom_range(0, 3);
          nr = $urandom_range(1, 24);
          nc = $urandom_range(1, 24);
        end
      endcase
      set_geometry(rr, rc, nr, nc);
      if (p == 9) begin
        tail_quiet = 1'b1;
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
      end
      load_kernel(p % 3 == 1);
      run_mixed_traffic(80, p % 3 == 1);
    end
  endtask

  initial begin
    int burst;
    burst = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (burst > 0) begin
        out_ready = 1'b0;
        burst = burst - 1;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        burst = $urandom_range(0, 9);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    conv_result_t seen, want;
    if (!rst && out_valid && out_ready) begin
      seen = '{pixel: result_pixel, peak: peak_pixel, clipped: window_clipped};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: pixel %0d max %0d clipped %0b",
                             seen.pixel, seen.peak, seen.clipped));
      end else begin
        want = pending_results.pop_front();
        if (seen.pixel !== want.pixel || seen.peak !== want.peak ||
            seen.clipped !== want.clipped) begin
          flag_error($sformatf({"result mismatch: expected pixel %0d max %0d clipped %0b, ",
                                "got pixel %0d max %0d clipped %0b"},
                               want.pixel, want.peak, want.clipped,
                               seen.pixel, seen.peak, seen.clipped));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    opcode = OP_WR_COEF;
    row = '0;
    col = '0;
    pixel_value = '0;
    coef_index = '0;
    coef_value = '0;
    error_count = 0;
    items_sent = 0;
    hold_cycles = 0;
    tail_quiet = 1'b0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    cfg_mirror = '{radius_rows: RST_RADIUS, radius_cols: RST_RADIUS,
                   image_rows: RST_DIM, image_cols: RST_DIM};
    peak_mirror = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_flow_control();
    test_random_phases();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("border_renormalized_convolution_unit_tb OK");
    end else begin
      $display("border_renormalized_convolution_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("border_renormalized_convolution_unit_tb NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/brc_pkg.sv
rtl/brc_apb.sv
rtl/brc_seq.sv
rtl/brc_mac.sv
rtl/brc_div.sv
rtl/border_renormalized_convolution_unit.sv
tb/sv/border_renormalized_convolution_unit_tb.sv
